// ----- rtl/core/pct_pkg.sv -----
package pct_pkg;
  localparam int unsigned Slots = 8;
  localparam int unsigned SlotW = $clog2(Slots);
  localparam logic [2:0] RetryLimit = 3'd3;

  typedef enum logic [2:0] {
    OP_BEGIN  = 3'd0,
    OP_ACK    = 3'd1,
    OP_RESULT = 3'd2,
    OP_CHECK  = 3'd3,
    OP_MARK   = 3'd4,
    OP_EXPIRE = 3'd5,
    OP_STATUS = 3'd6,
    OP_NONE   = 3'd7
  } op_e;

  typedef enum logic [2:0] {
    ST_EMPTY       = 3'd0,
    ST_WAIT_ACK    = 3'd1,
    ST_WAIT_RESULT = 3'd2,
    ST_DONE        = 3'd3,
    ST_FAILED      = 3'd4,
    ST_EXPIRED     = 3'd5
  } slot_st_e;

  // top level sequencing
  typedef enum logic [1:0] {S_IDLE, S_EXEC, S_READ} ph_e;

  localparam logic [2:0] AckAccepted  = 3'd0;
  localparam logic [2:0] AckDuplicate = 3'd1;
  localparam logic [7:0] StgExecuting = 8'd1;
  localparam logic [7:0] StgCompleted = 8'd2;
  localparam logic [7:0] StgExpired   = 8'd3;

  // broadcast beat driven into every cell
  typedef struct packed {
    logic        act;
    op_e         op;
    logic [63:0] token;
    logic [15:0] cmd_id;
    logic [15:0] ttl_ms;
    logic [31:0] now_ms;
    logic [2:0]  ack_code;
    logic [7:0]  result_stage;
  } cmd_t;

  // per cell status for the match / pick chain
  typedef struct packed {
    logic     hit;
    logic     used;
    logic     final_st;
    logic     due;
    logic     cmd_eq;
    slot_st_e st;
  } cell_stat_t;

  // chain carried from lower cells to upper ones
  typedef struct packed {
    logic found;
    logic free_seen;
    logic fin_seen;
  } chain_t;

  function automatic logic is_final(slot_st_e s);
    return s == ST_DONE || s == ST_FAILED || s == ST_EXPIRED;
  endfunction

  function automatic logic [7:0] backoff_ms(logic [2:0] r, logic [15:0] ttl);
    logic [7:0] d;
    logic [14:0] half;
    d = 8'd80;
    if (r == 3'd1) d = 8'd160;
    else if (r >= 3'd2) d = 8'd250;
    half = ttl[15:1];
    if ({7'd0, d} > half) d = half[7:0];
    return d;
  endfunction
endpackage

// ----- rtl/core/pct_cell.sv -----
module pct_cell (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  pct_pkg::cmd_t   cmd_i,
  input  logic            wr_i,
  input  pct_pkg::chain_t chain_i,
  output pct_pkg::chain_t chain_o,
  output logic            sel_o,
  output pct_pkg::cell_stat_t stat_o
);
  import pct_pkg::*;

  logic        used_q, used_d;
  logic [63:0] token_q, token_d;
  logic [15:0] cmdid_q, cmdid_d;
  logic [15:0] ttl_q, ttl_d;
  logic [31:0] sent_q, sent_d;
  logic [31:0] last_q, last_d;
  slot_st_e    st_q, st_d;
  logic [2:0]  retr_q, retr_d;

  logic hit, first_hit, fin, take, due;
  logic [7:0] dly;
  logic [31:0] age_send, age_sent;
  logic good_ack;

  always_comb begin
    hit       = used_q && token_q == cmd_i.token;
    first_hit = hit && !chain_i.found;
    fin       = is_final(st_q);
    dly       = backoff_ms(retr_q, ttl_q);
    age_send  = cmd_i.now_ms - last_q;
    age_sent  = cmd_i.now_ms - sent_q;
    due = st_q == ST_WAIT_ACK && retr_q < RetryLimit && dly != 8'd0 &&
          age_send >= {24'd0, dly};
    // free pick: lowest unused, else lowest finished
    if (!used_q) take = !chain_i.free_seen;
    else take = 1'b0;
    chain_o.found     = chain_i.found || hit;
    chain_o.free_seen = chain_i.free_seen || !used_q;
    chain_o.fin_seen  = chain_i.fin_seen || fin;
    good_ack = cmd_i.ack_code == AckAccepted || cmd_i.ack_code == AckDuplicate;
    stat_o.hit = first_hit;
    stat_o.used = used_q;
    stat_o.final_st = fin;
    stat_o.due = due;
    stat_o.cmd_eq = cmdid_q == cmd_i.cmd_id;
    stat_o.st = st_q;
  end

  // sel_o: this cell is the pick for begin given the chain totals
  assign sel_o = take || (used_q && fin && !chain_i.fin_seen);

  always_comb begin
    used_d = used_q; token_d = token_q; cmdid_d = cmdid_q; ttl_d = ttl_q;
    sent_d = sent_q; last_d = last_q; st_d = st_q; retr_d = retr_q;
    if (wr_i) begin
      used_d = 1'b1; token_d = cmd_i.token; cmdid_d = cmd_i.cmd_id;
      ttl_d = cmd_i.ttl_ms; sent_d = cmd_i.now_ms; last_d = cmd_i.now_ms;
      st_d = ST_WAIT_ACK; retr_d = 3'd0;
    end
    if (cmd_i.act) begin
      unique case (cmd_i.op)
        OP_ACK: if (first_hit && !fin) st_d = good_ack ? ST_WAIT_RESULT : ST_FAILED;
        OP_RESULT: begin
          if (first_hit && !fin && cmdid_q == cmd_i.cmd_id) begin
            if (cmd_i.result_stage <= StgExecuting) st_d = ST_WAIT_RESULT;
            else if (cmd_i.result_stage == StgCompleted) st_d = ST_DONE;
            else if (cmd_i.result_stage == StgExpired) st_d = ST_EXPIRED;
            else st_d = ST_FAILED;
          end
        end
        OP_MARK: if (first_hit && due) begin
          retr_d = retr_q + 3'd1;
          last_d = cmd_i.now_ms;
        end
        OP_EXPIRE: if (used_q && (st_q == ST_WAIT_ACK || st_q == ST_WAIT_RESULT) &&
                       age_sent >= {16'd0, ttl_q}) st_d = ST_EXPIRED;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0; st_q <= ST_EMPTY; token_q <= '0; cmdid_q <= '0;
      ttl_q <= '0; sent_q <= '0; last_q <= '0; retr_q <= '0;
    end else begin
      used_q <= used_d; st_q <= st_d; token_q <= token_d; cmdid_q <= cmdid_d;
      ttl_q <= ttl_d; sent_q <= sent_d; last_q <= last_d; retr_q <= retr_d;
    end
  end
endmodule

// ----- rtl/core/pending_command_tracker.sv -----
// channel  valid    stall    payload
// in       valid_i  stall_o  op_i token_i cmd_id_i ttl_ms_i now_ms_i ack_code_i result_stage_i
// out      valid_o  stall_i  ok_o slot_status_o
// a beat goes through capture, one update of the cell row, status readback
// the result is registered in readback, after the cell row update
// the cell row's compare/pick chain runs combinationally over all slots
// one beat at a time; a finished beat waits in readback while the output stalls
// reset clears every slot to empty
module pending_command_tracker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [2:0]  op_i,
  input  logic [63:0] token_i,
  input  logic [15:0] cmd_id_i,
  input  logic [15:0] ttl_ms_i,
  input  logic [31:0] now_ms_i,
  input  logic [2:0]  ack_code_i,
  input  logic [7:0]  result_stage_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic        ok_o,
  output logic [2:0]  slot_status_o
);
  import pct_pkg::*;

  ph_e ph_q, ph_d;
  cmd_t cmd_q, cmd_d, cmd_bc;
  logic ok_q, ok_d, vo_q, vo_d;
  logic okx_q, okx_d;
  logic [2:0] sts_q, sts_d;
  chain_t ch [Slots+1];
  cell_stat_t stat [Slots];
  logic [Slots-1:0] sel;
  logic [Slots-1:0] take;

  assign ch[0] = '{found: 1'b0, free_seen: 1'b0, fin_seen: 1'b0};

  // begin write path computed here, cells handle the rest
  logic beg_go;
  always_comb begin
    beg_go = cmd_q.token != 64'd0 && cmd_q.cmd_id != 16'd0 &&
             cmd_q.ttl_ms != 16'd0 && !ch[Slots].found;
    for (int i = 0; i < Slots; i++) begin
      if (ch[Slots].free_seen) take[i] = sel[i] && !stat[i].used;
      else take[i] = sel[i];
    end
    cmd_bc = cmd_q;
    cmd_bc.act = ph_q == S_EXEC;
  end

  // begin writes a fresh slot from here
  logic       wr_en;
  logic [Slots-1:0] wr_sel;
  assign wr_en  = ph_q == S_EXEC && cmd_q.op == OP_BEGIN && beg_go &&
                  (ch[Slots].free_seen || ch[Slots].fin_seen);
  assign wr_sel = take;

  for (genvar g = 0; g < Slots; g++) begin : g_cell
    pct_cell u_cell (
      .clk_i, .rst_ni,
      .cmd_i  (cmd_bc),
      .wr_i   (wr_en && wr_sel[g]),
      .chain_i(ch[g]),
      .chain_o(ch[g+1]),
      .sel_o  (sel[g]),
      .stat_o (stat[g])
    );
  end

  always_comb begin
    ph_d = ph_q; cmd_d = cmd_q; ok_d = ok_q; vo_d = vo_q; sts_d = sts_q;
    okx_d = okx_q;
    stall_o = ph_q != S_IDLE;
    if (vo_q && !stall_i) vo_d = 1'b0;
    unique case (ph_q)
      S_IDLE: if (valid_i && !stall_o) begin
        cmd_d = '{act: 1'b0, op: op_e'(op_i), token: token_i,
                  cmd_id: cmd_id_i, ttl_ms: ttl_ms_i, now_ms: now_ms_i,
                  ack_code: ack_code_i, result_stage: result_stage_i};
        ph_d = S_EXEC;
      end
      S_EXEC: begin
        okx_d = 1'b0;
        for (int i = 0; i < Slots; i++) begin
          if (stat[i].hit) begin
            unique case (cmd_q.op)
              OP_ACK: okx_d = cmd_q.ack_code == AckAccepted ||
                              cmd_q.ack_code == AckDuplicate;
              OP_RESULT: if (stat[i].cmd_eq)
                okx_d = stat[i].final_st ? (cmd_q.result_stage == StgCompleted &&
                        stat[i].st == ST_DONE) : 1'b1;
              OP_CHECK, OP_MARK: okx_d = stat[i].due;
              default: ;
            endcase
          end
        end
        if (cmd_q.op == OP_BEGIN) okx_d = wr_en;
        ph_d = S_READ;
      end
      S_READ: begin
        // hold here while the previous beat still sits in the output register
        if (!vo_q || !stall_i) begin
          ok_d = okx_q;
          sts_d = ST_EMPTY;
          for (int i = Slots - 1; i >= 0; i--) if (stat[i].hit) sts_d = stat[i].st;
          vo_d = 1'b1;
          ph_d = S_IDLE;
        end
      end
      default: ph_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ph_q <= S_IDLE; vo_q <= 1'b0;
    end else begin
      ph_q <= ph_d; vo_q <= vo_d;
    end
  end
  always_ff @(posedge clk_i) begin
    cmd_q <= cmd_d; ok_q <= ok_d; sts_q <= sts_d; okx_q <= okx_d;
  end

  assign valid_o = vo_q;
  assign ok_o = ok_q;
  assign slot_status_o = sts_q;
endmodule
